// ----- rtl/order_book_price_levels_core_assert.svh -----
// assertion macros for the price level table
`ifndef ORDER_BOOK_PRICE_LEVELS_CORE_ASSERT_SVH
`define ORDER_BOOK_PRICE_LEVELS_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define OBPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define OBPL_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define OBPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define OBPL_ASSERT(lbl, prop, msg)
`define OBPL_ASSERT_IMPLY(lbl, ante, cons, msg)
`define OBPL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/obpl_pkg.sv -----
package obpl_pkg;

  localparam logic [1:0] REQ_DELTA  = 2'd0;
  localparam logic [1:0] REQ_BEST   = 2'd1;
  localparam logic [1:0] REQ_VOLUME = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NO_LEVELS = 2'd3;

  localparam logic [6:0] MAX_RESULTS = 7'd64;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        book_side;
    logic [31:0] order_price;
    logic [31:0] level_qty;
    logic [6:0]  depth_req;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_price;
    logic [31:0] out_qty;
    logic [1:0]  status;
    logic        last_flag;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INS,
    OP_UPD,
    OP_DEL,
    OP_ROT
  } cell_op_t;

  typedef enum logic [1:0] {
    SR_NONE,
    SR_DELTA,
    SR_ROT,
    SR_CLR
  } side_req_t;

  typedef struct packed {
    logic found;
    logic full;
  } side_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ROT,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/order_book_price_levels_core.sv -----
// Two price-sorted level tables (bids highest first, asks lowest first), each a chain of
// LEVEL_DEPTH cells that shift levels to their neighbors on insert and remove. A delta or a
// clear is captured in the idle state, and the exec state then updates the chain and loads
// the result. A best-k query with nothing to report loads its status in the exec state;
// otherwise, after capture and setup, the occupied part of the chain rotates once through
// its head so that every level comes back in place, and the k best levels leave at one per
// cycle while the result register is not stalled, during the first k rotations. A volume
// lookup on an empty side loads its result in the exec state; otherwise the rotation scans
// every level and the done state then loads the result. A due result waits while the
// result register is still stalled. The result register lets the next transaction in while
// a result still waits; no clearing pass is needed after reset.
`include "order_book_price_levels_core_assert.svh"

module order_book_price_levels_core #(
  parameter int LEVEL_DEPTH = 64,
  parameter int PRICE_BITS  = 32,
  parameter int QTY_BITS    = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  obpl_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output obpl_pkg::out_item_t  out_item
);

  localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
  localparam int CW    = (CNT_W > 7) ? CNT_W : 7;

  obpl_pkg::state_t      state_r, state_nxt;
  obpl_pkg::in_item_t    req_r;
  logic [CNT_W-1:0]      rot_left_r, rot_left_nxt;
  logic [6:0]            emit_left_r, emit_left_nxt;
  logic                  hit_r, hit_nxt;
  logic [QTY_BITS-1:0]   hit_qty_r, hit_qty_nxt;
  logic                  out_valid_r;
  obpl_pkg::out_item_t   out_item_r, out_nxt;
  logic                  out_load;
  logic                  slot_free;

  logic [PRICE_BITS-1:0] key_price;
  logic [QTY_BITS-1:0]   key_qty;
  obpl_pkg::side_req_t   sel_req, bid_req, ask_req;
  logic                  clr;
  obpl_pkg::side_stat_t  bid_stat, ask_stat, sel_stat;
  logic [CNT_W-1:0]      bid_count, ask_count, sel_count;
  logic [PRICE_BITS-1:0] bid_head_price, ask_head_price, sel_head_price;
  logic [QTY_BITS-1:0]   bid_head_qty, ask_head_qty, sel_head_qty;
  logic [CW-1:0]         depth_cap, best_k;

  assign key_price = PRICE_BITS'(req_r.order_price);
  assign key_qty   = QTY_BITS'(req_r.level_qty);

  assign sel_stat       = req_r.book_side ? ask_stat : bid_stat;
  assign sel_count      = req_r.book_side ? ask_count : bid_count;
  assign sel_head_price = req_r.book_side ? ask_head_price : bid_head_price;
  assign sel_head_qty   = req_r.book_side ? ask_head_qty : bid_head_qty;

  assign bid_req = clr ? obpl_pkg::SR_CLR : (req_r.book_side ? obpl_pkg::SR_NONE : sel_req);
  assign ask_req = clr ? obpl_pkg::SR_CLR : (req_r.book_side ? sel_req : obpl_pkg::SR_NONE);

  assign depth_cap = (req_r.depth_req > obpl_pkg::MAX_RESULTS) ? CW'(obpl_pkg::MAX_RESULTS)
                                                                : CW'(req_r.depth_req);
  assign best_k    = (CW'(sel_count) < depth_cap) ? CW'(sel_count) : depth_cap;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != obpl_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  obpl_side #(
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .PRICE_BITS  (PRICE_BITS),
    .QTY_BITS    (QTY_BITS)
  ) u_bid (
    .clk        (clk),
    .rst_n      (rst_n),
    .is_ask     (1'b0),
    .req        (bid_req),
    .key_price  (key_price),
    .key_qty    (key_qty),
    .stat       (bid_stat),
    .count      (bid_count),
    .head_price (bid_head_price),
    .head_qty   (bid_head_qty)
  );

  obpl_side #(
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .PRICE_BITS  (PRICE_BITS),
    .QTY_BITS    (QTY_BITS)
  ) u_ask (
    .clk        (clk),
    .rst_n      (rst_n),
    .is_ask     (1'b1),
    .req        (ask_req),
    .key_price  (key_price),
    .key_qty    (key_qty),
    .stat       (ask_stat),
    .count      (ask_count),
    .head_price (ask_head_price),
    .head_qty   (ask_head_qty)
  );

  always_comb begin
    state_nxt     = state_r;
    rot_left_nxt  = rot_left_r;
    emit_left_nxt = emit_left_r;
    hit_nxt       = hit_r;
    hit_qty_nxt   = hit_qty_r;
    out_load      = 1'b0;
    out_nxt       = '0;
    sel_req       = obpl_pkg::SR_NONE;
    clr           = 1'b0;
    case (state_r)
      obpl_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = obpl_pkg::ST_EXEC;
        end
      end
      obpl_pkg::ST_EXEC: begin
        if (slot_free) begin
          state_nxt = obpl_pkg::ST_IDLE;
          case (req_r.req_type)
            obpl_pkg::REQ_DELTA: begin
              sel_req           = obpl_pkg::SR_DELTA;
              out_load          = 1'b1;
              out_nxt.out_price = 32'(key_price);
              out_nxt.out_qty   = 32'(key_qty);
              out_nxt.status    = (key_qty != '0 && !sel_stat.found && sel_stat.full)
                                  ? obpl_pkg::STAT_FULL : obpl_pkg::STAT_OK;
              out_nxt.last_flag = 1'b1;
            end
            obpl_pkg::REQ_BEST: begin
              if (best_k == '0) begin
                out_load          = 1'b1;
                out_nxt.status    = obpl_pkg::STAT_NO_LEVELS;
                out_nxt.last_flag = 1'b1;
              end else begin
                rot_left_nxt  = sel_count;
                emit_left_nxt = 7'(best_k);
                state_nxt     = obpl_pkg::ST_ROT;
              end
            end
            obpl_pkg::REQ_VOLUME: begin
              hit_nxt = 1'b0;
              if (sel_count == '0) begin
                out_load          = 1'b1;
                out_nxt.out_price = 32'(key_price);
                out_nxt.status    = obpl_pkg::STAT_NOT_FOUND;
                out_nxt.last_flag = 1'b1;
              end else begin
                rot_left_nxt  = sel_count;
                emit_left_nxt = '0;
                state_nxt     = obpl_pkg::ST_ROT;
              end
            end
            default: begin
              clr               = 1'b1;
              out_load          = 1'b1;
              out_nxt.status    = obpl_pkg::STAT_OK;
              out_nxt.last_flag = 1'b1;
            end
          endcase
        end
      end
      obpl_pkg::ST_ROT: begin
        if (emit_left_r == '0 || slot_free) begin
          sel_req      = obpl_pkg::SR_ROT;
          rot_left_nxt = rot_left_r - CNT_W'(1);
          if (emit_left_r != '0) begin
            out_load          = 1'b1;
            out_nxt.out_price = 32'(sel_head_price);
            out_nxt.out_qty   = 32'(sel_head_qty);
            out_nxt.status    = obpl_pkg::STAT_OK;
            out_nxt.last_flag = (emit_left_r == 7'd1);
            emit_left_nxt     = emit_left_r - 7'd1;
          end
          if (req_r.req_type == obpl_pkg::REQ_VOLUME && sel_head_price == key_price) begin
            hit_nxt     = 1'b1;
            hit_qty_nxt = sel_head_qty;
          end
          if (rot_left_r == CNT_W'(1)) begin
            state_nxt = (req_r.req_type == obpl_pkg::REQ_VOLUME) ? obpl_pkg::ST_DONE
                                                                   : obpl_pkg::ST_IDLE;
          end
        end
      end
      obpl_pkg::ST_DONE: begin
        if (slot_free) begin
          out_load          = 1'b1;
          out_nxt.out_price = 32'(key_price);
          out_nxt.out_qty   = hit_r ? 32'(hit_qty_r) : 32'd0;
          out_nxt.status    = hit_r ? obpl_pkg::STAT_OK : obpl_pkg::STAT_NOT_FOUND;
          out_nxt.last_flag = 1'b1;
          state_nxt         = obpl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = obpl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= obpl_pkg::ST_IDLE;
      rot_left_r  <= '0;
      emit_left_r <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rot_left_r  <= rot_left_nxt;
      emit_left_r <= emit_left_nxt;
      hit_r       <= hit_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hit_qty_r <= hit_qty_nxt;
    if (in_valid && !in_stall) begin
      req_r <= in_item;
    end
    if (out_load) begin
      out_item_r <= out_nxt;
    end
  end

  `OBPL_ASSERT_IMPLY(a_rot_pending, state_r == obpl_pkg::ST_ROT, rot_left_r != '0, "rotation with nothing left")
  `OBPL_ASSERT_IMPLY(a_emit_within_rot, state_r == obpl_pkg::ST_ROT, CW'(emit_left_r) <= CW'(rot_left_r), "more levels to send than rotations")
  `OBPL_ASSERT_IMPLY(a_load_free, out_load, slot_free, "result loaded over a waiting transaction")

endmodule

// ----- rtl/obpl_cell.sv -----
module obpl_cell #(
  parameter int PRICE_BITS = 32,
  parameter int QTY_BITS   = 32
) (
  input  logic                   clk,
  input  obpl_pkg::cell_op_t     op,
  input  logic                   is_ask,
  input  logic [PRICE_BITS-1:0]  key_price,
  input  logic [QTY_BITS-1:0]    key_qty,
  input  logic                   occ,
  input  logic                   tail,
  input  logic                   left_ahead,
  input  logic [PRICE_BITS-1:0]  left_price,
  input  logic [QTY_BITS-1:0]    left_qty,
  input  logic [PRICE_BITS-1:0]  right_price,
  input  logic [QTY_BITS-1:0]    right_qty,
  input  logic [PRICE_BITS-1:0]  head_price,
  input  logic [QTY_BITS-1:0]    head_qty,
  output logic [PRICE_BITS-1:0]  price,
  output logic [QTY_BITS-1:0]    qty,
  output logic                   ahead,
  output logic                   match
);

  logic [PRICE_BITS-1:0] price_r, price_nxt;
  logic [QTY_BITS-1:0]   qty_r, qty_nxt;

  // level sorts before the key on its side
  assign ahead = occ && (is_ask ? (price_r < key_price) : (price_r > key_price));
  assign match = occ && (price_r == key_price);
  assign price = price_r;
  assign qty   = qty_r;

  always_comb begin
    price_nxt = price_r;
    qty_nxt   = qty_r;
    case (op)
      obpl_pkg::OP_INS: begin
        if (!ahead) begin
          if (left_ahead) begin
            price_nxt = key_price;
            qty_nxt   = key_qty;
          end else begin
            price_nxt = left_price;
            qty_nxt   = left_qty;
          end
        end
      end
      obpl_pkg::OP_UPD: begin
        if (match) begin
          qty_nxt = key_qty;
        end
      end
      obpl_pkg::OP_DEL: begin
        if (!ahead) begin
          price_nxt = right_price;
          qty_nxt   = right_qty;
        end
      end
      obpl_pkg::OP_ROT: begin
        if (tail) begin
          price_nxt = head_price;
          qty_nxt   = head_qty;
        end else if (occ) begin
          price_nxt = right_price;
          qty_nxt   = right_qty;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    qty_r   <= qty_nxt;
  end

endmodule

// ----- rtl/obpl_side.sv -----
`include "order_book_price_levels_core_assert.svh"

module obpl_side #(
  parameter int LEVEL_DEPTH = 64,
  parameter int PRICE_BITS  = 32,
  parameter int QTY_BITS    = 32,
  localparam int CNT_W      = $clog2(LEVEL_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   is_ask,
  input  obpl_pkg::side_req_t    req,
  input  logic [PRICE_BITS-1:0]  key_price,
  input  logic [QTY_BITS-1:0]    key_qty,
  output obpl_pkg::side_stat_t   stat,
  output logic [CNT_W-1:0]       count,
  output logic [PRICE_BITS-1:0]  head_price,
  output logic [QTY_BITS-1:0]    head_qty
);

  logic [CNT_W-1:0]       count_r, count_nxt;
  obpl_pkg::cell_op_t     op;
  logic [PRICE_BITS-1:0]  cell_price [LEVEL_DEPTH];
  logic [QTY_BITS-1:0]    cell_qty [LEVEL_DEPTH];
  logic [LEVEL_DEPTH-1:0] cell_ahead;
  logic [LEVEL_DEPTH-1:0] cell_match;
  logic                   found;
  logic                   full;

  assign found      = |cell_match;
  assign full       = (count_r == CNT_W'(LEVEL_DEPTH));
  assign stat.found = found;
  assign stat.full  = full;
  assign count      = count_r;
  assign head_price = cell_price[0];
  assign head_qty   = cell_qty[0];

  always_comb begin
    op        = obpl_pkg::OP_HOLD;
    count_nxt = count_r;
    case (req)
      obpl_pkg::SR_DELTA: begin
        if (key_qty == '0) begin
          if (found) begin
            op        = obpl_pkg::OP_DEL;
            count_nxt = count_r - CNT_W'(1);
          end
        end else if (found) begin
          op = obpl_pkg::OP_UPD;
        end else if (!full) begin
          op        = obpl_pkg::OP_INS;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      obpl_pkg::SR_ROT: begin
        op = obpl_pkg::OP_ROT;
      end
      obpl_pkg::SR_CLR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < LEVEL_DEPTH; i++) begin : g_cell
    logic                  left_ahead;
    logic [PRICE_BITS-1:0] left_price;
    logic [QTY_BITS-1:0]   left_qty;
    logic [PRICE_BITS-1:0] right_price;
    logic [QTY_BITS-1:0]   right_qty;
    logic                  occ;
    logic                  tail;

    if (i == 0) begin : g_first
      assign left_ahead = 1'b1;
      assign left_price = key_price;
      assign left_qty   = key_qty;
    end else begin : g_inner_left
      assign left_ahead = cell_ahead[i-1];
      assign left_price = cell_price[i-1];
      assign left_qty   = cell_qty[i-1];
    end

    if (i == LEVEL_DEPTH - 1) begin : g_last
      assign right_price = cell_price[i];
      assign right_qty   = cell_qty[i];
    end else begin : g_inner_right
      assign right_price = cell_price[i+1];
      assign right_qty   = cell_qty[i+1];
    end

    assign occ  = (CNT_W'(i) < count_r);
    assign tail = (CNT_W'(i + 1) == count_r);

    obpl_cell #(
      .PRICE_BITS (PRICE_BITS),
      .QTY_BITS   (QTY_BITS)
    ) u_cell (
      .clk         (clk),
      .op          (op),
      .is_ask      (is_ask),
      .key_price   (key_price),
      .key_qty     (key_qty),
      .occ         (occ),
      .tail        (tail),
      .left_ahead  (left_ahead),
      .left_price  (left_price),
      .left_qty    (left_qty),
      .right_price (right_price),
      .right_qty   (right_qty),
      .head_price  (head_price),
      .head_qty    (head_qty),
      .price       (cell_price[i]),
      .qty         (cell_qty[i]),
      .ahead       (cell_ahead[i]),
      .match       (cell_match[i])
    );
  end

  `OBPL_ASSERT(a_count_range, count_r <= CNT_W'(LEVEL_DEPTH), "level count beyond depth")
  `OBPL_ASSERT_NEXT(a_clear_empties, req == obpl_pkg::SR_CLR, count_r == '0, "clear left levels")
  `OBPL_ASSERT_NEXT(a_insert_grows, op == obpl_pkg::OP_INS, count_r == $past(count_r) + CNT_W'(1), "insert did not grow side")

endmodule

// ----- tb/order_book_price_levels_core_tb.sv -----
module order_book_price_levels_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS = 64;
  localparam logic BID = 1'b0;
  localparam logic ASK = 1'b1;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  obpl_pkg::in_item_t  drv_item  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  obpl_pkg::out_item_t out_item;

  order_book_price_levels_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (drv_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // shadow copy of both sides, best level first
  logic [31:0]         book_px  [2][LEVELS];
  logic [31:0]         book_qty [2][LEVELS];
  int                  book_cnt [2];
  obpl_pkg::out_item_t level_reports_due [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int full_drops     = 0;
  int deepest_query  = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d level reports outstanding", level_reports_due.size());
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic int level_index(input int s, input logic [31:0] price);
    for (int i = 0; i < book_cnt[s]; i++)
      if (book_px[s][i] == price) return i;
    return -1;
  endfunction

  function automatic obpl_pkg::in_item_t mk_order(input logic [1:0] req, input logic side,
                                                  input logic [31:0] price,
                                                  input logic [31:0] qty,
                                                  input logic [6:0] depth);
    obpl_pkg::in_item_t it;
    it.req_type    = req;
    it.book_side   = side;
    it.order_price = price;
    it.level_qty   = qty;
    it.depth_req   = depth;
    return it;
  endfunction

  task automatic book_apply(input obpl_pkg::in_item_t it);
    int                  s;
    int                  at;
    int                  pos;
    int                  k;
    obpl_pkg::out_item_t r;
    s  = it.book_side;
    at = level_index(s, it.order_price);
    r  = '0;
    r.last_flag = 1'b1;
    case (it.req_type)
      obpl_pkg::REQ_DELTA: begin
        r.out_price = it.order_price;
        r.out_qty   = it.level_qty;
        r.status    = obpl_pkg::STAT_OK;
        if (it.level_qty == 32'd0) begin
          if (at >= 0) begin
            for (int i = at; i + 1 < book_cnt[s]; i++) begin
              book_px[s][i]  = book_px[s][i + 1];
              book_qty[s][i] = book_qty[s][i + 1];
            end
            book_cnt[s]--;
          end
        end else if (at >= 0) begin
          book_qty[s][at] = it.level_qty;
        end else if (book_cnt[s] >= LEVELS) begin
          r.status = obpl_pkg::STAT_FULL;
          full_drops++;
        end else begin
          pos = 0;
          while (pos < book_cnt[s] && (s == 1 ? book_px[s][pos] < it.order_price
                                               : book_px[s][pos] > it.order_price))
            pos++;
          for (int i = book_cnt[s]; i > pos; i--) begin
            book_px[s][i]  = book_px[s][i - 1];
            book_qty[s][i] = book_qty[s][i - 1];
          end
          book_px[s][pos]  = it.order_price;
          book_qty[s][pos] = it.level_qty;
          book_cnt[s]++;
        end
        level_reports_due.push_back(r);
      end
      obpl_pkg::REQ_BEST: begin
        k = it.depth_req;
        if (k > book_cnt[s]) k = book_cnt[s];
        if (k > int'(obpl_pkg::MAX_RESULTS)) k = int'(obpl_pkg::MAX_RESULTS);
        if (k > deepest_query) deepest_query = k;
        if (k == 0) begin
          r.status = obpl_pkg::STAT_NO_LEVELS;
          level_reports_due.push_back(r);
        end else begin
          for (int i = 0; i < k; i++) begin
            r.out_price = book_px[s][i];
            r.out_qty   = book_qty[s][i];
            r.status    = obpl_pkg::STAT_OK;
            r.last_flag = (i == k - 1);
            level_reports_due.push_back(r);
          end
        end
      end
      obpl_pkg::REQ_VOLUME: begin
        if (at < 0) begin
          r.out_price = it.order_price;
          r.status    = obpl_pkg::STAT_NOT_FOUND;
        end else begin
          r.out_price = book_px[s][at];
          r.out_qty   = book_qty[s][at];
          r.status    = obpl_pkg::STAT_OK;
        end
        level_reports_due.push_back(r);
      end
      default: begin
        book_cnt[0] = 0;
        book_cnt[1] = 0;
        r.status = obpl_pkg::STAT_OK;
        level_reports_due.push_back(r);
      end
    endcase
  endtask

  task automatic send_order(input obpl_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    drv_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book_apply(it);
    items_sent++;
  endtask

  task automatic wait_book_settled();
    in_valid <= 1'b0;
    do @(posedge clk); while (level_reports_due.size() != 0);
  endtask

  always @(posedge clk) begin
    obpl_pkg::out_item_t want;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (level_reports_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result price %0h qty %0h status %0d",
                                  out_item.out_price, out_item.out_qty, out_item.status));
      end else begin
        want = level_reports_due.pop_front();
        if (out_item.out_price !== want.out_price)
          report_mismatch($sformatf("out_price got %0h want %0h",
                                    out_item.out_price, want.out_price));
        if (out_item.out_qty !== want.out_qty)
          report_mismatch($sformatf("out_qty got %0h want %0h",
                                    out_item.out_qty, want.out_qty));
        if (out_item.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_item.status, want.status));
        if (out_item.last_flag !== want.last_flag)
          report_mismatch($sformatf("last_flag got %0b want %0b",
                                    out_item.last_flag, want.last_flag));
      end
    end
  end

  function automatic obpl_pkg::in_item_t random_order();
    obpl_pkg::in_item_t it;
    int                 s;
    int                 roll;
    s    = $urandom_range(1);
    roll = $urandom_range(99);
    it   = mk_order(obpl_pkg::REQ_DELTA, s[0], $urandom, $urandom,
                    7'($urandom_range(64)));
    if (roll < 55) begin
      if (book_cnt[s] > 0 && $urandom_range(2) == 0)
        it.order_price = book_px[s][$urandom_range(book_cnt[s] - 1)];
      else if ($urandom_range(4) != 0)
        it.order_price = 32'h0001_0000 + $urandom_range(95);
      case ($urandom_range(7))
        0, 1:    it.level_qty = 32'd0;
        2:       it.level_qty = 32'hFFFF_FFFF;
        3:       it.level_qty = $urandom;
        default: it.level_qty = $urandom_range(1, 1000);
      endcase
    end else if (roll < 75) begin
      it.req_type = obpl_pkg::REQ_BEST;
      case ($urandom_range(5))
        0:       it.depth_req = 7'd0;
        1:       it.depth_req = 7'd64;
        2:       it.depth_req = 7'($urandom_range(64));
        default: it.depth_req = 7'($urandom_range(1, 8));
      endcase
    end else if (roll < 95) begin
      it.req_type = obpl_pkg::REQ_VOLUME;
      if (book_cnt[s] > 0 && $urandom_range(4) < 3)
        it.order_price = book_px[s][$urandom_range(book_cnt[s] - 1)];
      else if ($urandom_range(1) == 0)
        it.order_price = 32'h0001_0000 + $urandom_range(95);
    end else begin
      it.req_type = obpl_pkg::REQ_CLEAR;
    end
    return it;
  endfunction

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_order(mk_order(obpl_pkg::REQ_CLEAR,  BID, 32'h0,         32'h0,         7'd0));
    send_order(mk_order(obpl_pkg::REQ_BEST,   BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd5));
    send_order(mk_order(obpl_pkg::REQ_VOLUME, ASK, 32'd100,       32'd0,         7'd0));
    send_order(mk_order(obpl_pkg::REQ_DELTA,  BID, 32'd0,         32'd1,         7'd0));
    send_order(mk_order(obpl_pkg::REQ_DELTA,  BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0));
    send_order(mk_order(obpl_pkg::REQ_DELTA,  BID, 32'd1000,      32'd7,         7'd0));
    send_order(mk_order(obpl_pkg::REQ_DELTA,  ASK, 32'hFFFF_FFFF, 32'd3,         7'd0));
    send_order(mk_order(obpl_pkg::REQ_DELTA,  ASK, 32'd0,         32'hFFFF_FFFF, 7'd0));
    send_order(mk_order(obpl_pkg::REQ_DELTA,  ASK, 32'd500,       32'd9,         7'd0));
    send_order(mk_order(obpl_pkg::REQ_DELTA,  BID, 32'd1000,      32'd12,        7'd0));
    send_order(mk_order(obpl_pkg::REQ_DELTA,  BID, 32'd1234,      32'd0,         7'd0));
    send_order(mk_order(obpl_pkg::REQ_BEST,   BID, 32'd0,         32'd0,         7'd64));
    send_order(mk_order(obpl_pkg::REQ_BEST,   ASK, 32'd0,         32'd0,         7'd0));
    send_order(mk_order(obpl_pkg::REQ_BEST,   ASK, 32'd0,         32'd0,         7'd2));
    send_order(mk_order(obpl_pkg::REQ_VOLUME, BID, 32'd1000,      32'hFFFF_FFFF, 7'd0));
    send_order(mk_order(obpl_pkg::REQ_VOLUME, BID, 32'd999,       32'd0,         7'd0));
    send_order(mk_order(obpl_pkg::REQ_DELTA,  BID, 32'hFFFF_FFFF, 32'd0,         7'd0));
    send_order(mk_order(obpl_pkg::REQ_DELTA,  ASK, 32'hFFFF_FFFF, 32'd0,         7'd0));
    send_order(mk_order(obpl_pkg::REQ_BEST,   BID, 32'd0,         32'd0,         7'd1));
    send_order(mk_order(obpl_pkg::REQ_BEST,   ASK, 32'd0,         32'd0,         7'd64));
    send_order(mk_order(obpl_pkg::REQ_CLEAR,  ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127));
    send_order(mk_order(obpl_pkg::REQ_BEST,   BID, 32'd0,         32'd0,         7'd3));
    send_order(mk_order(obpl_pkg::REQ_VOLUME, ASK, 32'd500,       32'd0,         7'd0));
    wait_book_settled();
  endtask

  task automatic test_full_side();
    logic [31:0] base;
    logic        s;
    base           = 32'h2000_0000;
    s              = ASK;
    send_idle_pct  = 0;
    recv_stall_pct = 30;
    send_order(mk_order(obpl_pkg::REQ_CLEAR, BID, 32'd0, 32'd0, 7'd0));
    // scattered order so inserts land at head, middle and tail
    for (int i = 0; i < LEVELS; i++)
      send_order(mk_order(obpl_pkg::REQ_DELTA, s, base + ((i * 37) % LEVELS) * 5,
                          $urandom_range(1, 500), 7'd0));
    // hold off until the whole side is reported back
    wait_book_settled();
    send_order(mk_order(obpl_pkg::REQ_DELTA,  s, base + 1,      32'd77, 7'd0));
    send_order(mk_order(obpl_pkg::REQ_DELTA,  s, base,          32'd42, 7'd0));
    send_order(mk_order(obpl_pkg::REQ_BEST,   s, 32'd0,         32'd0,  7'd64));
    send_order(mk_order(obpl_pkg::REQ_VOLUME, s, base + 63 * 5, 32'd0,  7'd0));
    send_order(mk_order(obpl_pkg::REQ_DELTA,  s, base + 10,     32'd0,  7'd0));
    send_order(mk_order(obpl_pkg::REQ_DELTA,  s, base + 1,      32'd77, 7'd0));
    send_order(mk_order(obpl_pkg::REQ_BEST,   s, 32'd0,         32'd0,  7'd64));
    send_order(mk_order(obpl_pkg::REQ_CLEAR, ASK, 32'd0, 32'd0, 7'd0));
    wait_book_settled();
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_order(random_order());
    wait_book_settled();
  endtask

  initial begin
    book_cnt[0] = 0;
    book_cnt[1] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_side();
    test_random(4, 0, 0);
    test_random(4, 70, 0);
    test_random(4, 0, 70);
    test_random(4, 7, 7);
    recv_stall_pct = 0;
    repeat (100) @(posedge clk);
    if (level_reports_due.size() != 0)
      report_mismatch($sformatf("%0d level reports never arrived", level_reports_due.size()));
    $display("run covered %0d transactions in and %0d level reports out", items_sent,
             results_seen);
    $display("full-side drops %0d, deepest best-k %0d levels, %0d mismatches", full_drops,
             deepest_query, error_count);
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/obpl_pkg.sv
rtl/obpl_cell.sv
rtl/obpl_side.sv
rtl/order_book_price_levels_core.sv
tb/order_book_price_levels_core_tb.sv
